@@ src/drgb_pkg.sv @@
// Shared types, codes and helpers for the damage-rectangle RGB565 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package drgb_pkg;

   typedef enum logic [1:0] {
      CMD_BEGIN_LIST = 2'd0,
      CMD_RECT       = 2'd1,
      CMD_FULL_FRAME = 2'd2,
      CMD_PIXEL      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_BAD_RECT   = 3'd1,
      STAT_TOO_MANY   = 3'd2,
      STAT_BAD_HEIGHT = 3'd3,
      STAT_NO_ACTIVE  = 3'd4
   } status_type;

   typedef enum logic {
      REG_CONTENT_ROWS  = 1'b0,
      REG_DEST_OFFSET_Y = 1'b1
   } csr_index_type;

   localparam logic [9:0] CONTENT_ROWS_RESET = 10'd240;
   localparam logic [9:0] DEST_OFFSET_RESET  = 10'd0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;

   // One classified command on its way from the front end to the back end.
   typedef struct packed {
      status_type  status;
      logic        pixel_ok;
      logic [15:0] pixel_value;
      logic [9:0]  cursor_x;
      logic [9:0]  cursor_y;
      logic        rect_done;
      logic        list_valid;
   } job_type;

   // RGB565 to 24-bit color by replicating the top bits into the low bits.
   function automatic logic [23:0] widen565(input logic [15:0] p);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      r = p[15:11];
      g = p[10:5];
      b = p[4:0];
      return {r, r[4:2], g, g[5:4], b, b[4:2]};
   endfunction

endpackage

`default_nettype wire

@@ src/drgb_front.sv @@
// Front end: accepts commands, checks rectangles and walks the raster cursor.
// Depends on drgb_pkg; feeds classified jobs to drgb_queue.
`default_nettype none

module drgb_front
   import drgb_pkg::*;
#(
   parameter int DISPLAY_WIDTH   = 320,
   parameter int DISPLAY_HEIGHT  = 240,
   parameter int STANDARD_HEIGHT = 224,
   parameter int MAX_RECTS       = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire cmd_type     cmd,
   input  wire logic [9:0]  rect_x,
   input  wire logic [9:0]  rect_y,
   input  wire logic [10:0] rect_width,
   input  wire logic [10:0] rect_height,
   input  wire logic [15:0] pixel_value,
   input  wire logic [9:0]  content_rows,
   output job_type          job
);

   localparam logic [11:0] WIDTH_12   = 12'(DISPLAY_WIDTH);
   localparam logic [10:0] WIDTH_11   = 11'(DISPLAY_WIDTH);
   localparam logic [10:0] DISP_H_11  = 11'(DISPLAY_HEIGHT);
   localparam logic [10:0] STD_H_11   = 11'(STANDARD_HEIGHT);
   localparam logic [4:0]  MAX_R_5    = 5'(MAX_RECTS);

   logic [9:0]  cursor_x_ff, cursor_x_in;
   logic [9:0]  cursor_y_ff, cursor_y_in;
   logic [9:0]  left_col_ff, left_col_in;
   logic [10:0] right_end_ff, right_end_in;
   logic [10:0] bottom_end_ff, bottom_end_in;
   logic        active_ff, active_in;
   logic [4:0]  rect_count_ff, rect_count_in;
   logic        list_good_ff, list_good_in;

   logic        height_ok;
   logic [11:0] x_end;
   logic [11:0] y_end;
   logic [10:0] x_next;
   logic [10:0] y_next;
   status_type  status;

   assign height_ok = ({1'b0, content_rows} == STD_H_11) ||
                      ({1'b0, content_rows} == DISP_H_11);
   assign x_end  = {2'b00, rect_x} + {1'b0, rect_width};
   assign y_end  = {2'b00, rect_y} + {1'b0, rect_height};
   assign x_next = {1'b0, cursor_x_ff} + 11'd1;
   assign y_next = {1'b0, cursor_y_ff} + 11'd1;

   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      left_col_in   = left_col_ff;
      right_end_in  = right_end_ff;
      bottom_end_in = bottom_end_ff;
      active_in     = active_ff;
      rect_count_in = rect_count_ff;
      list_good_in  = list_good_ff;
      status        = STAT_OK;
      job           = '0;

      unique case (cmd)
         CMD_BEGIN_LIST: begin
            rect_count_in = 5'd0;
            list_good_in  = 1'b1;
            active_in     = 1'b0;
         end
         CMD_RECT: begin
            active_in = 1'b0;
            if (!height_ok) begin
               status = STAT_BAD_HEIGHT;
            end else if (rect_count_ff >= MAX_R_5) begin
               status = STAT_TOO_MANY;
            end else if (rect_width == 11'd0 || rect_height == 11'd0 ||
                         x_end > WIDTH_12 || y_end > {2'b00, content_rows}) begin
               status = STAT_BAD_RECT;
            end else begin
               rect_count_in = rect_count_ff + 5'd1;
               cursor_x_in   = rect_x;
               cursor_y_in   = rect_y;
               left_col_in   = rect_x;
               right_end_in  = x_end[10:0];
               bottom_end_in = y_end[10:0];
               active_in     = 1'b1;
            end
            if (status != STAT_OK) begin
               list_good_in = 1'b0;
            end
         end
         CMD_FULL_FRAME: begin
            active_in = 1'b0;
            if (!height_ok) begin
               status       = STAT_BAD_HEIGHT;
               list_good_in = 1'b0;
            end else begin
               cursor_x_in   = 10'd0;
               cursor_y_in   = 10'd0;
               left_col_in   = 10'd0;
               right_end_in  = WIDTH_11;
               bottom_end_in = {1'b0, content_rows};
               active_in     = 1'b1;
            end
         end
         CMD_PIXEL: begin
            if (!active_ff) begin
               status = STAT_NO_ACTIVE;
            end else begin
               job.pixel_ok    = 1'b1;
               job.pixel_value = pixel_value;
               job.cursor_x    = cursor_x_ff;
               job.cursor_y    = cursor_y_ff;
               if (x_next >= right_end_ff) begin
                  cursor_x_in = left_col_ff;
                  if (y_next >= bottom_end_ff) begin
                     active_in     = 1'b0;
                     job.rect_done = 1'b1;
                     cursor_y_in   = 10'd0;
                  end else begin
                     cursor_y_in = y_next[9:0];
                  end
               end else begin
                  cursor_x_in = x_next[9:0];
               end
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase

      job.status     = status;
      job.list_valid = list_good_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         left_col_ff   <= '0;
         right_end_ff  <= '0;
         bottom_end_ff <= '0;
         active_ff     <= 1'b0;
         rect_count_ff <= '0;
         list_good_ff  <= 1'b1;
      end else if (accept) begin
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         left_col_ff   <= left_col_in;
         right_end_ff  <= right_end_in;
         bottom_end_ff <= bottom_end_in;
         active_ff     <= active_in;
         rect_count_ff <= rect_count_in;
         list_good_ff  <= list_good_in;
      end
   end

`ifndef SYNTHESIS
   a_cursor_x_in_rect: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ({1'b0, cursor_x_ff} < right_end_ff))
      else $error("cursor column outside active rectangle");

   a_cursor_y_in_rect: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> ({1'b0, cursor_y_ff} < bottom_end_ff))
      else $error("cursor row outside active rectangle");

   a_rect_count_limit: assert property (@(posedge clock) disable iff (reset)
      rect_count_ff <= MAX_R_5)
      else $error("rectangle count above limit");
`endif

endmodule

`default_nettype wire

@@ src/drgb_queue.sv @@
// Short job queue between front end and back end.
// Depends on drgb_pkg for the job type and depth constants.
`default_nettype none

module drgb_queue
   import drgb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire job_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output job_type      pop_data
);

   localparam logic [QCOUNT_W-1:0] DEPTH_C = QCOUNT_W'(QUEUE_DEPTH);

   job_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = (count_ff != DEPTH_C);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count above depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCOUNT_W'(1)))
      else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

@@ src/drgb_back.sv @@
// Back end: widens the color, forms source and destination addresses, holds the result.
// Depends on drgb_pkg; drains jobs from drgb_queue.
`default_nettype none

module drgb_back
   import drgb_pkg::*;
#(
   parameter int DISPLAY_WIDTH = 320
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   output logic             job_ready,
   input  wire job_type     job,
   input  wire logic [9:0]  dest_offset_y,
   output logic             out_valid,
   input  wire logic        out_ready,
   output status_type       out_status,
   output logic [23:0]      out_color,
   output logic [20:0]      out_source_addr,
   output logic [20:0]      out_dest_index,
   output logic             out_rect_done,
   output logic             out_list_valid
);

   localparam logic [20:0] WIDTH_21 = 21'(DISPLAY_WIDTH);

   // stage A: products registered
   logic        a_valid_ff, a_valid_in;
   status_type  a_status_ff;
   logic        a_pixel_ok_ff;
   logic [23:0] a_color_ff;
   logic [9:0]  a_col_ff;
   logic [20:0] a_src_row_ff;
   logic [20:0] a_dst_row_ff;
   logic        a_done_ff;
   logic        a_list_ff;

   // stage B: output register
   logic        b_valid_ff, b_valid_in;
   status_type  b_status_ff;
   logic [23:0] b_color_ff;
   logic [20:0] b_saddr_ff;
   logic [20:0] b_didx_ff;
   logic        b_done_ff;
   logic        b_list_ff;

   logic        advance_b;
   logic        load_a;
   logic [10:0] dst_row_num;
   logic [20:0] src_row_in;
   logic [20:0] dst_row_in;
   logic [20:0] src_sum;
   logic [20:0] dst_sum;

   assign advance_b = !b_valid_ff || out_ready;
   assign load_a    = !a_valid_ff || advance_b;
   assign job_ready = load_a;

   assign dst_row_num = {1'b0, job.cursor_y} + {1'b0, dest_offset_y};
   assign src_row_in  = {11'd0, job.cursor_y} * WIDTH_21;
   assign dst_row_in  = {10'd0, dst_row_num} * WIDTH_21;

   assign src_sum = a_src_row_ff + {11'd0, a_col_ff};
   assign dst_sum = a_dst_row_ff + {11'd0, a_col_ff};

   assign a_valid_in = load_a ? job_valid : a_valid_ff;
   assign b_valid_in = advance_b ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_status_ff   <= job.status;
         a_pixel_ok_ff <= job.pixel_ok;
         a_color_ff    <= widen565(job.pixel_value);
         a_col_ff      <= job.cursor_x;
         a_src_row_ff  <= src_row_in;
         a_dst_row_ff  <= dst_row_in;
         a_done_ff     <= job.rect_done;
         a_list_ff     <= job.list_valid;
      end
      if (advance_b) begin
         b_status_ff <= a_status_ff;
         b_color_ff  <= a_pixel_ok_ff ? a_color_ff : 24'd0;
         b_saddr_ff  <= a_pixel_ok_ff ? {src_sum[19:0], 1'b0} : 21'd0;
         b_didx_ff   <= a_pixel_ok_ff ? dst_sum : 21'd0;
         b_done_ff   <= a_pixel_ok_ff && a_done_ff;
         b_list_ff   <= a_list_ff;
      end
   end

   assign out_valid       = b_valid_ff;
   assign out_status      = b_status_ff;
   assign out_color       = b_color_ff;
   assign out_source_addr = b_saddr_ff;
   assign out_dest_index  = b_didx_ff;
   assign out_rect_done   = b_done_ff;
   assign out_list_valid  = b_list_ff;

endmodule

`default_nettype wire

@@ src/damage_rect_rgb565_converter.sv @@
// Top level of the damage-rectangle RGB565 to XRGB8888 converter.
// Depends on drgb_pkg, drgb_front, drgb_queue and drgb_back; holds the CSR block.
//
//   channel | ports      | direction | carries
//   --------+------------+-----------+--------------------------------------------
//   request | req_t*     | in        | commands: begin list, rect, full frame, pixel
//   response| rsp_t*     | out       | one result per command: status, color, addrs
//   csr     | csr_p*     | in/out    | rows of content (0x0), dest_offset_y (0x4)
//
// Throughput is one command per clock while the job queue has room; the front
// end settles cursor and list state in the cycle a transfer is taken, so
// commands may follow back to back. After the request transfer the job enters
// the queue, then the product stage (row times display width), then the
// output register that drives rsp_tvalid.
// A stalled response fills the four-entry job queue; req_tready drops only
// when that queue is full. Reset is synchronous and active high and needs no
// clearing pass; CSR writes are only expected while the block is idle.
`default_nettype none

module damage_rect_rgb565_converter
   import drgb_pkg::*;
#(
   parameter int DISPLAY_WIDTH   = 320,
   parameter int DISPLAY_HEIGHT  = 240,
   parameter int STANDARD_HEIGHT = 224,
   parameter int MAX_RECTS       = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rect_x[9:0], rect_y[19:10], rect_width[30:20], rect_height[41:31],
   // pixel_value[57:42], zero fill [63:58]
   input  wire logic [63:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]  req_tuser,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // color[23:0], source_addr[44:24], dest_index[65:45], list_valid[66],
   // zero fill [71:67]
   output logic [71:0]      rsp_tdata,
   // status[2:0]
   output logic [2:0]       rsp_tuser,
   // rect_done
   output logic             rsp_tlast,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // CSR block
   logic [9:0]    content_rows_ff, content_rows_in;
   logic [9:0]    dest_offset_y_ff, dest_offset_y_in;
   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      content_rows_in  = content_rows_ff;
      dest_offset_y_in = dest_offset_y_ff;
      csr_prdata       = 32'd0;
      unique case (csr_index)
         REG_CONTENT_ROWS: begin
            csr_prdata = {22'd0, content_rows_ff};
            if (csr_write) begin
               content_rows_in = csr_pwdata[9:0];
            end
         end
         REG_DEST_OFFSET_Y: begin
            csr_prdata = {22'd0, dest_offset_y_ff};
            if (csr_write) begin
               dest_offset_y_in = csr_pwdata[9:0];
            end
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         content_rows_ff  <= CONTENT_ROWS_RESET;
         dest_offset_y_ff <= DEST_OFFSET_RESET;
      end else begin
         content_rows_ff  <= content_rows_in;
         dest_offset_y_ff <= dest_offset_y_in;
      end
   end

   // front end -> queue -> back end
   job_type    front_job;
   job_type    back_job;
   logic       req_accept;
   logic       job_valid;
   logic       job_ready;
   status_type out_status;
   logic [23:0] out_color;
   logic [20:0] out_saddr;
   logic [20:0] out_didx;
   logic        out_list;

   assign req_accept = req_tvalid && req_tready;

   drgb_front #(
      .DISPLAY_WIDTH   (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT  (DISPLAY_HEIGHT),
      .STANDARD_HEIGHT (STANDARD_HEIGHT),
      .MAX_RECTS       (MAX_RECTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .cmd            (cmd_type'(req_tuser)),
      .rect_x         (req_tdata[9:0]),
      .rect_y         (req_tdata[19:10]),
      .rect_width     (req_tdata[30:20]),
      .rect_height    (req_tdata[41:31]),
      .pixel_value    (req_tdata[57:42]),
      .content_rows   (content_rows_ff),
      .job            (front_job)
   );

   drgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (front_job),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (back_job)
   );

   drgb_back #(
      .DISPLAY_WIDTH (DISPLAY_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job             (back_job),
      .dest_offset_y   (dest_offset_y_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_status      (out_status),
      .out_color       (out_color),
      .out_source_addr (out_saddr),
      .out_dest_index  (out_didx),
      .out_rect_done   (rsp_tlast),
      .out_list_valid  (out_list)
   );

   assign rsp_tdata = {5'd0, out_list, out_didx, out_saddr, out_color};
   assign rsp_tuser = out_status;

endmodule

`default_nettype wire

@@ tb/sv/drgb_conversion_checker.sv @@
// Scoreboard for the damage-rectangle RGB565 converter: watches request, response and CSR
// traffic, predicts each response and compares it field by field.
// Depends on drgb_pkg for the command, status and register codes.
module drgb_conversion_checker
   import drgb_pkg::*;
#(
   parameter int DISPLAY_WIDTH   = 320,
   parameter int DISPLAY_HEIGHT  = 240,
   parameter int STANDARD_HEIGHT = 224,
   parameter int MAX_RECTS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      status_type  status;
      logic [23:0] color;
      logic [20:0] src_addr;
      logic [20:0] dst_index;
      logic        done;
      logic        list_valid;
   } conv_result_type;

   conv_result_type expected_results[$];

   // predicted block state
   logic [9:0]  content_rows;
   logic [9:0]  dest_offset_y;
   logic [9:0]  cur_x;
   logic [9:0]  cur_y;
   logic [9:0]  left_col;
   logic [10:0] right_end;
   logic [10:0] bottom_end;
   logic        active;
   logic [4:0]  rect_count;
   logic        list_good;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
   endtask

   function automatic logic height_valid();
      return content_rows == 10'(STANDARD_HEIGHT) || content_rows == 10'(DISPLAY_HEIGHT);
   endfunction

   task automatic open_rect(input logic [9:0] x, input logic [9:0] y,
                            input logic [10:0] x_end, input logic [10:0] y_end);
      cur_x = x;
      cur_y = y;
      left_col = x;
      right_end = x_end;
      bottom_end = y_end;
      active = 1'b1;
   endtask

   task automatic convert_command(input cmd_type c, input logic [63:0] d);
      logic [9:0]      x;
      logic [9:0]      y;
      logic [10:0]     w;
      logic [10:0]     h;
      logic [15:0]     pv;
      conv_result_type r;
      x = d[9:0];
      y = d[19:10];
      w = d[30:20];
      h = d[41:31];
      pv = d[57:42];
      r = '0;
      r.status = STAT_OK;
      case (c)
         CMD_BEGIN_LIST: begin
            rect_count = '0;
            list_good = 1'b1;
            active = 1'b0;
         end
         CMD_RECT: begin
            active = 1'b0;
            if (!height_valid())
               r.status = STAT_BAD_HEIGHT;
            else if (int'(rect_count) >= MAX_RECTS)
               r.status = STAT_TOO_MANY;
            else if (w == 0 || h == 0 || int'(x) + int'(w) > DISPLAY_WIDTH ||
                     int'(y) + int'(h) > int'(content_rows))
               r.status = STAT_BAD_RECT;
            else begin
               rect_count = rect_count + 5'd1;
               open_rect(x, y, 11'(int'(x) + int'(w)), 11'(int'(y) + int'(h)));
            end
            if (r.status != STAT_OK)
               list_good = 1'b0;
         end
         CMD_FULL_FRAME: begin
            active = 1'b0;
            if (!height_valid()) begin
               r.status = STAT_BAD_HEIGHT;
               list_good = 1'b0;
            end else
               open_rect('0, '0, 11'(DISPLAY_WIDTH), {1'b0, content_rows});
         end
         default: begin
            if (!active)
               r.status = STAT_NO_ACTIVE;
            else begin
               // each channel widened by repeating its top bits below it
               r.color[23:16] = {pv[15:11], pv[15:13]};
               r.color[15:8]  = {pv[10:5], pv[10:9]};
               r.color[7:0]   = {pv[4:0], pv[4:2]};
               r.src_addr  = 21'((int'(cur_y) * DISPLAY_WIDTH + int'(cur_x)) * 2);
               r.dst_index = 21'((int'(cur_y) + int'(dest_offset_y)) * DISPLAY_WIDTH
                                 + int'(cur_x));
               if (int'(cur_x) + 1 >= int'(right_end)) begin
                  cur_x = left_col;
                  if (int'(cur_y) + 1 >= int'(bottom_end)) begin
                     active = 1'b0;
                     r.done = 1'b1;
                     cur_y = '0;
                  end else
                     cur_y = cur_y + 10'd1;
               end else
                  cur_x = cur_x + 10'd1;
            end
         end
      endcase
      r.list_valid = list_good;
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      conv_result_type want;
      if (reset) begin
         expected_results.delete();
         content_rows = CONTENT_ROWS_RESET;
         dest_offset_y = DEST_OFFSET_RESET;
         cur_x = '0;
         cur_y = '0;
         left_col = '0;
         right_end = '0;
         bottom_end = '0;
         active = 1'b0;
         rect_count = '0;
         list_good = 1'b1;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == {REG_CONTENT_ROWS, 2'b00})
                  content_rows = csr_pwdata[9:0];
               else if (csr_paddr == {REG_DEST_OFFSET_Y, 2'b00})
                  dest_offset_y = csr_pwdata[9:0];
            end else if (csr_paddr == {REG_CONTENT_ROWS, 2'b00}) begin
               if (csr_prdata[9:0] != content_rows)
                  note_mismatch("content rows read", csr_prdata, content_rows);
            end else if (csr_paddr == {REG_DEST_OFFSET_Y, 2'b00}) begin
               if (csr_prdata[9:0] != dest_offset_y)
                  note_mismatch("dest_offset_y read", csr_prdata, dest_offset_y);
            end
         end
         if (req_tvalid && req_tready)
            convert_command(cmd_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0)
               note_mismatch("result with nothing outstanding, status", rsp_tuser, 0);
            else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.status)
                  note_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[23:0] != want.color)
                  note_mismatch("color", rsp_tdata[23:0], want.color);
               if (rsp_tdata[44:24] != want.src_addr)
                  note_mismatch("source_addr", rsp_tdata[44:24], want.src_addr);
               if (rsp_tdata[65:45] != want.dst_index)
                  note_mismatch("dest_index", rsp_tdata[65:45], want.dst_index);
               if (rsp_tdata[66] != want.list_valid)
                  note_mismatch("list_valid", rsp_tdata[66], want.list_valid);
               if (rsp_tlast != want.done)
                  note_mismatch("rect_done", rsp_tlast, want.done);
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

@@ tb/sv/damage_rect_rgb565_converter_test.sv @@
// Top of the converter regression: clock, reset, stimulus, CSR phases and the verdict.
// Depends on drgb_pkg, damage_rect_rgb565_converter and drgb_conversion_checker.
module damage_rect_rgb565_converter_test;
   import drgb_pkg::*;

   localparam int DISPLAY_WIDTH   = 320;
   localparam int DISPLAY_HEIGHT  = 240;
   localparam int STANDARD_HEIGHT = 224;
   localparam int MAX_RECTS       = 16;

   localparam int N_PHASES     = 8;
   localparam int GOOD_QUOTA   = 180;   // items per phase, valid height
   localparam int BAD_QUOTA    = 90;    // items per phase, invalid height
   localparam int HOLD_CYCLES  = 300;   // long response hold-off
   localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
   localparam int DRAIN_CYCLES = 8;     // extra wait once nothing is pending

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;

   // sender burst shaping and stimulus bookkeeping
   int burst_left;
   int item_count;       // request transfers in the current phase
   int phase_quota;
   int list_count;       // rects accepted since the last begin_list, as far as stimulus knows
   int cur_height;
   bit hold_armed;
   bit hold_taken;

   damage_rect_rgb565_converter #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
      .STANDARD_HEIGHT(STANDARD_HEIGHT),
      .MAX_RECTS(MAX_RECTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   drgb_conversion_checker #(
      .DISPLAY_WIDTH(DISPLAY_WIDTH),
      .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
      .STANDARD_HEIGHT(STANDARD_HEIGHT),
      .MAX_RECTS(MAX_RECTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: any transfer on any port restarts the count. The longest legal
   // quiet stretch is the response hold-off, well under the limit.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet = 0;
      else
         quiet++;
      if (quiet >= IDLE_LIMIT) begin
         $display("damage_rect_rgb565_converter regression: fail");
         $finish;
      end
   end

   // Response side: stall modes last a random number of cycles each (always
   // ready, coin flip, fixed one-in-five stall, mostly stalled). Once armed
   // by the stimulus, a single long hold-off lets the job queue fill up and
   // push back on the request side.
   initial begin
      int mode;
      int mode_left;
      int tick;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (tick % 5) != 0;
               default: rsp_tready <= $urandom_range(0, 3) == 0;
            endcase
         end
      end
   end

   function automatic logic [63:0] pack_request(input logic [9:0] x, input logic [9:0] y,
                                                input logic [10:0] w, input logic [10:0] h,
                                                input logic [15:0] pv);
      return {6'd0, pv, h, w, y, x};
   endfunction

   // junk in every field; the block must ignore what a command does not use
   function automatic logic [63:0] random_fields();
      return {6'd0, 26'($urandom), 32'($urandom)};
   endfunction

   // One request transfer. Runs from a falling edge to the falling edge after
   // the transfer; bursts of random length are separated by random gaps, and
   // half of the gaps are empty so long back-to-back stretches occur too.
   task automatic send_command(input cmd_type c, input logic [63:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= c;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      item_count++;
   endtask

   task automatic send_pixels(input int n);
      for (int i = 0; i < n; i++)
         send_command(CMD_PIXEL, random_fields());
   endtask

   task automatic csr_access(input logic write, input csr_index_type idx,
                             input logic [9:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {22'($urandom), value};   // upper bits are not stored
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Registers may only change with nothing in flight.
   task automatic drain_and_configure(input logic [9:0] height, input logic [9:0] offset);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_access(1'b1, REG_CONTENT_ROWS, height);
      csr_access(1'b1, REG_DEST_OFFSET_Y, offset);
      csr_access(1'b0, REG_CONTENT_ROWS, '0);
      csr_access(1'b0, REG_DEST_OFFSET_Y, '0);
      cur_height = height;
   endtask

   // A list: begin_list (usually), then up to 20 rects, so the rect limit is
   // crossed now and then. Valid rects mostly get exactly their pixel count;
   // some are cut short and some get stray pixels past the end. The list
   // stops early once the phase has sent its share of items.
   task automatic random_list();
      int n_rects;
      int kind;
      int w;
      int h;
      int x;
      int y;
      int npix;
      int y_room;
      bit height_good;
      bit accepted;
      cmd_type c;
      height_good = cur_height == STANDARD_HEIGHT || cur_height == DISPLAY_HEIGHT;
      y_room = height_good ? cur_height : DISPLAY_HEIGHT;
      if ($urandom_range(0, 9) != 0) begin
         send_command(CMD_BEGIN_LIST, random_fields());
         list_count = 0;
      end
      n_rects = $urandom_range(1, 20);
      for (int k = 0; k < n_rects && item_count < phase_quota; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            // full frame is never walked to the end; a long partial walk crosses rows
            send_command(CMD_FULL_FRAME, random_fields());
            send_pixels($urandom_range(1, 400));
         end else if (kind < 12) begin
            case ($urandom_range(0, 4))
               0: send_command(CMD_RECT, pack_request(10'($urandom_range(0, 319)), '0, '0,
                                                      11'($urandom_range(1, 4)), '0));
               1: send_command(CMD_RECT, pack_request('0, 10'($urandom_range(0, 100)),
                                                      11'($urandom_range(1, 4)), '0, '0));
               2: send_command(CMD_RECT, pack_request(10'($urandom_range(300, 1023)), '0,
                                                      11'($urandom_range(21, 2047)), 11'd1,
                                                      '0));
               3: send_command(CMD_RECT, pack_request('0, 10'(y_room - 1), 11'd1,
                                                      11'($urandom_range(2, 2047)), '0));
               default: send_command(CMD_RECT, random_fields());
            endcase
            send_pixels($urandom_range(0, 2));
         end else if (kind < 17) begin
            c = cmd_type'($urandom_range(0, 3));
            send_command(c, random_fields());
            if (c == CMD_BEGIN_LIST)
               list_count = 0;
         end else begin
            if (kind < 20) begin
               // the largest shapes: a full-width row or a full-height column
               if ($urandom_range(0, 1)) begin
                  w = DISPLAY_WIDTH;
                  h = 1;
               end else begin
                  w = 1;
                  h = y_room;
               end
            end else begin
               w = $urandom_range(1, 6);
               h = $urandom_range(1, 4);
            end
            if ($urandom_range(0, 7) == 0) begin
               x = DISPLAY_WIDTH - w;   // hug the bottom-right corner
               y = y_room - h;
            end else begin
               x = $urandom_range(0, DISPLAY_WIDTH - w);
               y = $urandom_range(0, y_room - h);
            end
            send_command(CMD_RECT, pack_request(10'(x), 10'(y), 11'(w), 11'(h),
                                                16'($urandom)));
            accepted = height_good && list_count < MAX_RECTS;
            if (accepted)
               list_count++;
            npix = w * h;
            case ($urandom_range(0, 19))
               0: npix = $urandom_range(0, w * h - 1);
               1: npix = npix + $urandom_range(1, 2);
               default: ;
            endcase
            send_pixels(npix);
         end
      end
   endtask

   initial begin
      logic [9:0] height;
      logic [9:0] offset;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_BEGIN_LIST;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_left = 0;
      item_count = 0;
      phase_quota = 0;
      list_count = 0;
      cur_height = CONTENT_ROWS_RESET;
      hold_armed = 1'b0;
      hold_taken = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of both registers
      csr_access(1'b0, REG_CONTENT_ROWS, '0);
      csr_access(1'b0, REG_DEST_OFFSET_Y, '0);

      // Directed part, at the reset settings.
      // pixel with no rect open gets a no-active status
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'hffff));
      send_command(CMD_BEGIN_LIST, '0);
      // 2x2 at the origin with color extremes, done on the fourth pixel
      send_command(CMD_RECT, pack_request('0, '0, 11'd2, 11'd2, '0));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h0000));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'hffff));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'hf800));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h07e0));
      // single pixel in the bottom-right corner
      send_command(CMD_RECT, pack_request(10'd319, 10'd239, 11'd1, 11'd1, '0));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h001f));
      // zero width, zero height, everything at its maximum, one row too tall
      send_command(CMD_RECT, pack_request(10'd5, 10'd5, 11'd0, 11'd3, '0));
      send_command(CMD_RECT, pack_request(10'd5, 10'd5, 11'd3, 11'd0, '0));
      send_command(CMD_RECT, pack_request(10'h3ff, 10'h3ff, 11'h7ff, 11'h7ff, 16'hffff));
      send_command(CMD_RECT, pack_request('0, 10'd239, 11'd1, 11'd2, '0));
      // full frame, two pixels, then abandoned by a new list
      send_command(CMD_FULL_FRAME, '0);
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h1234));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h8421));
      send_command(CMD_BEGIN_LIST, '0);
      // rect that is cut off by another rect after one pixel
      send_command(CMD_RECT, pack_request(10'd10, 10'd20, 11'd3, 11'd2, '0));
      send_command(CMD_PIXEL, pack_request('0, '0, '0, '0, 16'h5555));
      send_command(CMD_RECT, pack_request(10'd0, 10'd0, 11'd320, 11'd1, '0));

      // Random part: one register setting per phase. Heights cover both valid
      // values and invalid extremes; offsets cover both ends of the range.
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin height = 10'd240; offset = 10'd0; end
            1: begin height = 10'd224; offset = 10'd1023; end
            2: begin height = 10'd224; offset = 10'($urandom_range(1, 1022)); end
            3: begin height = 10'd0; offset = 10'd0; end
            4: begin height = 10'd240; offset = 10'd1023; end
            5: begin height = 10'd1023; offset = 10'($urandom_range(0, 1023)); end
            6: begin height = 10'd224; offset = 10'd0; end
            default: begin height = 10'd240; offset = 10'($urandom_range(1, 1022)); end
         endcase
         drain_and_configure(height, offset);
         phase_quota = (height == STANDARD_HEIGHT || height == DISPLAY_HEIGHT) ?
                       GOOD_QUOTA : BAD_QUOTA;
         item_count = 0;
         if (p == 0)
            hold_armed = 1'b1;   // the sender keeps offering through the hold-off
         while (item_count < phase_quota)
            random_list();
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("damage_rect_rgb565_converter regression: pass");
      else
         $display("damage_rect_rgb565_converter regression: fail");
      $finish;
   end

endmodule
